@@ design/pek_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pek_pkg;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_SCALE  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_WEIGHT = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ANG_WEIGHT = 4'd3;

    localparam logic [31:0] CFG_RESET = 32'd65536;

    localparam logic [15:0] TWO_PI_Q12 = 16'd25736;

    localparam int SQRT_BITS   = 32;
    localparam int EXP_TERMS   = 20;
    localparam int EXP_SUBST   = 3;
    localparam int EXP_STAGES  = EXP_TERMS * EXP_SUBST;
    localparam int MUL_STAGES  = 31;

    localparam int SQ_BASE  = 3;
    localparam int P_BASE   = SQ_BASE + SQRT_BITS;
    localparam int EX_BASE  = P_BASE + 4;
    localparam int MC_BASE  = EX_BASE + EXP_STAGES;
    localparam int FIN_BASE = MC_BASE + MUL_STAGES;
    localparam int NUM_STAGES = FIN_BASE + 3;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    typedef struct packed {
        logic        diag;
        logic [31:0] diag_val;
        logic        last;
    } side_t;

    // series terms of exp(-1/2) in Q0.32, each term is the previous halved over k
    localparam logic [63:0] HT1  = (64'h1_0000_0000 >> 1) / 64'd1;
    localparam logic [63:0] HT2  = (HT1  >> 1) / 64'd2;
    localparam logic [63:0] HT3  = (HT2  >> 1) / 64'd3;
    localparam logic [63:0] HT4  = (HT3  >> 1) / 64'd4;
    localparam logic [63:0] HT5  = (HT4  >> 1) / 64'd5;
    localparam logic [63:0] HT6  = (HT5  >> 1) / 64'd6;
    localparam logic [63:0] HT7  = (HT6  >> 1) / 64'd7;
    localparam logic [63:0] HT8  = (HT7  >> 1) / 64'd8;
    localparam logic [63:0] HT9  = (HT8  >> 1) / 64'd9;
    localparam logic [63:0] HT10 = (HT9  >> 1) / 64'd10;
    localparam logic [63:0] HT11 = (HT10 >> 1) / 64'd11;
    localparam logic [63:0] HT12 = (HT11 >> 1) / 64'd12;
    localparam logic [63:0] HT13 = (HT12 >> 1) / 64'd13;
    localparam logic [63:0] HT14 = (HT13 >> 1) / 64'd14;
    localparam logic [63:0] HT15 = (HT14 >> 1) / 64'd15;
    localparam logic [63:0] HT16 = (HT15 >> 1) / 64'd16;
    localparam logic [63:0] HT17 = (HT16 >> 1) / 64'd17;
    localparam logic [63:0] HT18 = (HT17 >> 1) / 64'd18;
    localparam logic [63:0] HT19 = (HT18 >> 1) / 64'd19;
    localparam logic [63:0] HT20 = (HT19 >> 1) / 64'd20;

    localparam logic [63:0] HALF_EXP = 64'h1_0000_0000
        - HT1 + HT2 - HT3 + HT4 - HT5 + HT6 - HT7 + HT8 - HT9 + HT10
        - HT11 + HT12 - HT13 + HT14 - HT15 + HT16 - HT17 + HT18 - HT19 + HT20;
    localparam logic [63:0] EM1_FULL = (HALF_EXP * HALF_EXP) >> 32;
    localparam logic [31:0] EM1      = EM1_FULL[31:0];

endpackage

`default_nettype wire

@@ design/pose_exponential_kernel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// exponential covariance kernel over pairs of planar poses
// input channel (in_valid/in_ready): one word per pose pair, with the
// diagonal flag, noise variance and a last marker
// output channel (out_valid/out_ready): one word per input word, in order,
// kernel_value in unsigned Q16.16 and last_value copied from last_pair
// config channel (cfg_valid/cfg_ready): cfg_index selects amplitude,
// inv_scale, pos_weight or ang_weight; other indexes are dropped; always ready
// the path from input accept to out_valid runs through the 32 stage
// square root, the 60 stage exp series (three stages per term) and the
// 31 stage e^-1 multiply chain
// throughput is one word per cycle while out_ready stays high
// when out_valid is high and out_ready is low the whole pipeline holds;
// an empty front stage still takes a new word
// reset clears all valid bits and loads 1.0 into the four config registers
module pose_exponential_kernel #(
    parameter int EXP_FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [pek_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] first_x,
    input  wire logic [31:0] first_y,
    input  wire logic [15:0] first_heading,
    input  wire logic [31:0] second_x,
    input  wire logic [31:0] second_y,
    input  wire logic [15:0] second_heading,
    input  wire logic        diagonal_entry,
    input  wire logic [31:0] noise_var,
    input  wire logic        last_pair,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      kernel_value,
    output logic             last_value
);
    import pek_pkg::*;

    localparam int EW = EXP_FRAC_BITS + 1;

    logic [31:0] amplitude_reg;
    logic [31:0] inv_scale_reg;
    logic [31:0] pos_weight_reg;
    logic [31:0] ang_weight_reg;

    logic        vld_reg [NUM_STAGES];
    side_t       side_reg [NUM_STAGES];
    logic        adv;
    logic        en0;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg  <= CFG_RESET;
            inv_scale_reg  <= CFG_RESET;
            pos_weight_reg <= CFG_RESET;
            ang_weight_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_AMPLITUDE:  amplitude_reg  <= cfg_data;
                REG_INV_SCALE:  inv_scale_reg  <= cfg_data;
                REG_POS_WEIGHT: pos_weight_reg <= cfg_data;
                REG_ANG_WEIGHT: ang_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign adv      = !vld_reg[NUM_STAGES-1] || out_ready;
    assign en0      = adv || !vld_reg[0];
    assign in_ready = en0;

    side_t side_next;
    logic [32:0] diag_sum;

    assign diag_sum = {1'b0, amplitude_reg} + {1'b0, noise_var};

    always_comb
    begin
        side_next.diag     = diagonal_entry;
        side_next.diag_val = diag_sum[32] ? 32'hFFFF_FFFF : diag_sum[31:0];
        side_next.last     = last_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            if (en0)
                vld_reg[0] <= in_valid;
            if (adv)
            begin
                for (int i = 1; i < NUM_STAGES; i++)
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
            side_reg[0] <= side_next;
        if (adv)
        begin
            for (int i = 1; i < NUM_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // stage 0: clamped distances and folded heading
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic [30:0]        ax_next;
    logic [30:0]        ay_next;
    logic signed [16:0] dh;
    logic [15:0]        adh;
    logic [15:0]        dmod;
    logic [15:0]        dfold;
    logic [13:0]        ang_next;
    logic [30:0]        ax_reg;
    logic [30:0]        ay_reg;
    logic [13:0]        ang_reg;

    always_comb
    begin
        dx  = $signed({first_x[31], first_x}) - $signed({second_x[31], second_x});
        dy  = $signed({first_y[31], first_y}) - $signed({second_y[31], second_y});
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
        ax_next = (adx > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : adx[30:0];
        ay_next = (ady > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ady[30:0];
        dh  = $signed({first_heading[15], first_heading})
            - $signed({second_heading[15], second_heading});
        adh = dh[16] ? 16'(-dh) : dh[15:0];
        if (adh >= 16'(2 * TWO_PI_Q12))
            dmod = adh - 16'(2 * TWO_PI_Q12);
        else if (adh >= TWO_PI_Q12)
            dmod = adh - TWO_PI_Q12;
        else
            dmod = adh;
        dfold = ((TWO_PI_Q12 - dmod) < dmod) ? (TWO_PI_Q12 - dmod) : dmod;
        ang_next = dfold[13:0];
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            ang_reg <= ang_next;
        end
    end

    // stage 1: squares
    logic [61:0] sqx_reg;
    logic [61:0] sqy_reg;
    logic [13:0] ang1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg  <= ax_reg * ax_reg;
            sqy_reg  <= ay_reg * ay_reg;
            ang1_reg <= ang_reg;
        end
    end

    // stage 2: sum of squares, weighted heading term
    logic [62:0] v_reg;
    logic [33:0] a_reg;
    logic [49:0] a_prod;

    assign a_prod = {18'd0, ang_weight_reg} * {32'd0, ang1_reg, 4'd0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            a_reg <= a_prod[49:16];
        end
    end

    // square root, one result bit per stage
    logic [31:0] sq_root_reg [SQRT_BITS];
    logic [62:0] sq_rem_reg  [SQRT_BITS];
    logic [33:0] sq_a_reg    [SQRT_BITS];

    for (genvar j = 0; j < SQRT_BITS; j++)
    begin : g_sqrt
        localparam int B = SQRT_BITS - 1 - j;
        logic [31:0] root_in;
        logic [62:0] rem_in;
        logic [33:0] a_in;
        logic [63:0] trial;
        logic        fit;
        logic [63:0] rem_diff;
        logic [31:0] root_next;
        logic [62:0] rem_next;

        if (j == 0)
        begin : g_first
            assign root_in = '0;
            assign rem_in  = v_reg;
            assign a_in    = a_reg;
        end
        else
        begin : g_rest
            assign root_in = sq_root_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign a_in    = sq_a_reg[j-1];
        end

        assign trial     = ({32'd0, root_in} << (B + 1)) | (64'd1 << (2 * B));
        assign fit       = {1'b0, rem_in} >= trial;
        assign rem_diff  = {1'b0, rem_in} - trial;
        assign rem_next  = fit ? rem_diff[62:0] : rem_in;
        assign root_next = fit ? (root_in | (32'd1 << B)) : root_in;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_root_reg[j] <= root_next;
                sq_rem_reg[j]  <= rem_next;
                sq_a_reg[j]    <= a_in;
            end
        end
    end

    // exponent
    logic [63:0] p_prod_reg;
    logic [33:0] p_a_reg;
    logic [48:0] s_reg;
    logic [63:0] m_lo_reg;
    logic [48:0] m_hi_reg;
    logic [80:0] m_full;
    logic        e_zero_reg;
    logic [4:0]  e_n_reg;
    logic [15:0] e_frac_reg;

    assign m_full = {m_hi_reg, 32'd0} + {17'd0, m_lo_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_prod_reg <= pos_weight_reg * sq_root_reg[SQRT_BITS-1];
            p_a_reg    <= sq_a_reg[SQRT_BITS-1];
            s_reg      <= {1'b0, p_prod_reg[63:16]} + {15'd0, p_a_reg};
            m_lo_reg   <= inv_scale_reg * s_reg[31:0];
            m_hi_reg   <= {17'd0, inv_scale_reg} * {32'd0, s_reg[48:32]};
            e_zero_reg <= |m_full[80:37];
            e_n_reg    <= m_full[36:32];
            e_frac_reg <= m_full[31:16];
        end
    end

    // taylor series of exp(-f), three stages per term
    logic [32:0] ex_sum_reg  [EXP_STAGES];
    logic [32:0] ex_val_reg  [EXP_STAGES];
    logic [15:0] ex_frac_reg [EXP_STAGES];
    logic [4:0]  ex_n_reg    [EXP_STAGES];
    logic        ex_zero_reg [EXP_STAGES];
    logic [32:0] ex_xh_reg   [EXP_TERMS];

    for (genvar g = 0; g < EXP_TERMS; g++)
    begin : g_term
        localparam int K  = g + 1;
        localparam int S0 = EXP_SUBST * g;
        localparam bit ODD_K = (K % 2) == 1;
        localparam logic [33:0] RECIP_W = ((34'd1 << 33) + 34'(K) - 34'd1) / 34'(K);
        localparam logic [32:0] RECIP = RECIP_W[32:0];
        logic [32:0] term_in;
        logic [32:0] sum_in;
        logic [15:0] frac_in;
        logic [4:0]  n_in;
        logic        zero_in;
        logic [48:0] tf;
        logic [32:0] x_next;
        logic [32:0] q0_next;
        logic [38:0] chk;
        logic [32:0] q_next;
        logic [32:0] sum_next;

        if (g == 0)
        begin : g_first
            assign term_in = ONE_Q32;
            assign sum_in  = ONE_Q32;
            assign frac_in = e_frac_reg;
            assign n_in    = e_n_reg;
            assign zero_in = e_zero_reg;
        end
        else
        begin : g_rest
            assign term_in = ex_val_reg[S0-1];
            assign sum_in  = ex_sum_reg[S0-1];
            assign frac_in = ex_frac_reg[S0-1];
            assign n_in    = ex_n_reg[S0-1];
            assign zero_in = ex_zero_reg[S0-1];
        end

        assign tf     = {16'd0, term_in} * {33'd0, frac_in};
        assign x_next = tf[48:16];

        if (K == 1)
        begin : g_unit
            assign q0_next = ex_val_reg[S0];
        end
        else
        begin : g_recip
            logic [65:0] qp;
            assign qp      = {33'd0, ex_val_reg[S0]} * {33'd0, RECIP};
            assign q0_next = qp[65:33];
        end

        assign chk      = {6'd0, ex_val_reg[S0+1]} * 39'(K);
        assign q_next   = (chk > {6'd0, ex_xh_reg[g]}) ? ex_val_reg[S0+1] - 33'd1
                                                      : ex_val_reg[S0+1];
        assign sum_next = ODD_K ? ex_sum_reg[S0+1] - q_next
                                : ex_sum_reg[S0+1] + q_next;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ex_val_reg[S0]    <= x_next;
                ex_sum_reg[S0]    <= sum_in;
                ex_frac_reg[S0]   <= frac_in;
                ex_n_reg[S0]      <= n_in;
                ex_zero_reg[S0]   <= zero_in;

                ex_val_reg[S0+1]  <= q0_next;
                ex_xh_reg[g]      <= ex_val_reg[S0];
                ex_sum_reg[S0+1]  <= ex_sum_reg[S0];
                ex_frac_reg[S0+1] <= ex_frac_reg[S0];
                ex_n_reg[S0+1]    <= ex_n_reg[S0];
                ex_zero_reg[S0+1] <= ex_zero_reg[S0];

                ex_val_reg[S0+2]  <= q_next;
                ex_sum_reg[S0+2]  <= sum_next;
                ex_frac_reg[S0+2] <= ex_frac_reg[S0+1];
                ex_n_reg[S0+2]    <= ex_n_reg[S0+1];
                ex_zero_reg[S0+2] <= ex_zero_reg[S0+1];
            end
        end
    end

    // integer part: one e^-1 multiply per stage
    logic [32:0] mc_r_reg    [MUL_STAGES];
    logic [4:0]  mc_n_reg    [MUL_STAGES];
    logic        mc_zero_reg [MUL_STAGES];

    for (genvar i = 0; i < MUL_STAGES; i++)
    begin : g_mul
        logic [32:0] r_in;
        logic [4:0]  n_in;
        logic        zero_in;
        logic [64:0] rp;
        logic [32:0] r_next;

        if (i == 0)
        begin : g_first
            assign r_in    = ex_sum_reg[EXP_STAGES-1];
            assign n_in    = ex_n_reg[EXP_STAGES-1];
            assign zero_in = ex_zero_reg[EXP_STAGES-1];
        end
        else
        begin : g_rest
            assign r_in    = mc_r_reg[i-1];
            assign n_in    = mc_n_reg[i-1];
            assign zero_in = mc_zero_reg[i-1];
        end

        assign rp     = {32'd0, r_in} * {33'd0, EM1};
        assign r_next = (n_in > 5'(i)) ? rp[64:32] : r_in;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mc_r_reg[i]    <= r_next;
                mc_n_reg[i]    <= n_in;
                mc_zero_reg[i] <= zero_in;
            end
        end
    end

    // scale by amplitude, select diagonal result
    logic [EW-1:0]    e_reg;
    logic [32+EW-1:0] k_prod_reg;
    logic [31:0]      kv_reg;
    logic [31:0]      kv_next;

    assign kv_next = side_reg[NUM_STAGES-2].diag ? side_reg[NUM_STAGES-2].diag_val
                                                : k_prod_reg[EXP_FRAC_BITS +: 32];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg      <= mc_zero_reg[MUL_STAGES-1] ? '0
                        : mc_r_reg[MUL_STAGES-1][32 -: EW];
            k_prod_reg <= {{EW{1'b0}}, amplitude_reg} * {32'd0, e_reg};
            kv_reg     <= kv_next;
        end
    end

    assign out_valid    = vld_reg[NUM_STAGES-1];
    assign kernel_value = kv_reg;
    assign last_value   = side_reg[NUM_STAGES-1].last;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with empty output");

    a_shift_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid == $past(vld_reg[NUM_STAGES-2]))
        else $error("output valid did not follow pipeline");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_BASE-1] |->
        ({1'b0, sq_rem_reg[SQRT_BITS-1]} <= {31'd0, sq_root_reg[SQRT_BITS-1], 1'b0}))
        else $error("square root remainder out of range");

    a_series_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[MC_BASE-1] |-> (ex_sum_reg[EXP_STAGES-1] <= ONE_Q32))
        else $error("exp series above one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(kv_reg) && $stable(side_reg[NUM_STAGES-1]))
        else $error("output stage changed while stalled");
`endif

endmodule

`default_nettype wire
